[sv/sdtq_pkg.sv]
package sdtq_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);
    localparam int TIME_BITS  = 32;
    localparam int DELAY_BITS = 32;
    localparam int COOKIE_BITS = 32;

    localparam logic [DELAY_BITS-1:0] IDLE_RESET = DELAY_BITS'(1000);

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_MODIFY   = 2'd1;
    localparam logic [1:0] CMD_DELETE   = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_UNCHANGED = 2'd1;
    localparam logic [1:0] STAT_FIRED     = 2'd2;
    localparam logic [1:0] STAT_NONE      = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_MOD_RD,
        SEQ_MOD_CHK,
        SEQ_UNLINK,
        SEQ_WRITE,
        SEQ_FIND_RD,
        SEQ_FIND_CMP,
        SEQ_SHIFT,
        SEQ_PLACE,
        SEQ_DISP_RD,
        SEQ_DISP_CMP,
        SEQ_HEAD_RD,
        SEQ_HEAD_CMP,
        SEQ_COOK_RD,
        SEQ_FIRE,
        SEQ_FINAL
    } seq_state_t;

endpackage

[sv/sdtq_ram.sv]
module sdtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/sorted_deadline_timer_queue.sv]
// channel   dir  handshake         tdata / tuser / tlast
// s_*       in   s_tvalid/s_tready command in tuser; timer_id, expires, cookie, now in tdata
// m_*       out  m_tvalid/m_tready status in tuser; fired_id, fired_cookie, next_delay in tdata
// cfg_*     in   cfg_we            idle_delay value on cfg_wdata
//
// one request at a time; delete makes an unlink pass over the queued entries if the timer is
// pending; add and modify add to that a read and a compare per entry passed and a step per
// shifted entry; dispatch reads and compares each queued entry, then emits each fired timer
// the pace is set by the single expiry memory port and the one shared subtractor
// reset clears queue count and pending flags, sets idle delay to 1000; no clearing pass
// a stalled result holds the sequencer; a new request is taken once the last result
// of the previous one sits in the output register
module sorted_deadline_timer_queue
    import sdtq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // timer_id, expires, cookie, now, zero pad
    input  logic [1:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // fired_id, fired_cookie, next_delay, zero pad
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    seq_state_t state_reg, state_next;

    logic [1:0]             cmd_reg, cmd_next;
    logic [SLOT_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0]   exp_reg, exp_next;
    logic [COOKIE_BITS-1:0] ck_reg, ck_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [1:0]             status_reg, status_next;
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    keep_reg, keep_next;
    logic [CNT_BITS-1:0]    pos_reg, pos_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    nfire_reg, nfire_next;
    logic [CNT_BITS-1:0]    emit_reg, emit_next;
    logic [DELAY_BITS-1:0]  nd_reg, nd_next;
    logic [DELAY_BITS-1:0]  idle_reg;
    logic [SLOT_COUNT-1:0]  pending_reg, pending_next;

    logic [SLOT_BITS-1:0]   order_reg [SLOT_COUNT];
    logic [SLOT_BITS-1:0]   fire_reg [SLOT_COUNT];

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [SLOT_BITS-1:0]   out_id_reg, out_id_next;
    logic [COOKIE_BITS-1:0] out_ck_reg, out_ck_next;
    logic [DELAY_BITS-1:0]  out_nd_reg, out_nd_next;
    logic                   out_last_reg, out_last_next;

    logic                   ord_we;
    logic [SLOT_BITS-1:0]   ord_waddr;
    logic [SLOT_BITS-1:0]   ord_wdata;
    logic [SLOT_BITS-1:0]   ord_raddr;
    logic [SLOT_BITS-1:0]   ord_rd;

    logic                   fire_we;

    logic                   exp_we;
    logic [SLOT_BITS-1:0]   exp_raddr;
    logic [TIME_BITS-1:0]   exp_rdata;
    logic                   ck_we;
    logic [COOKIE_BITS-1:0] ck_rdata;

    logic [TIME_BITS-1:0]   op_a, op_b, diff;

    logic                   s_fire;
    logic                   out_free;
    logic                   last_elem;
    logic                   keep_elem;
    logic [SLOT_BITS-1:0]   idx_lo;

    assign s_tready = (state_reg == SEQ_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_lo   = idx_reg[SLOT_BITS-1:0];
    assign last_elem = (idx_reg == count_reg - CNT_BITS'(1));
    assign ord_rd   = order_reg[ord_raddr];
    assign diff     = op_a - op_b;

    sdtq_ram #(
        .WIDTH(TIME_BITS),
        .DEPTH(SLOT_COUNT)
    ) u_expiry_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (id_reg),
        .wdata (exp_reg),
        .raddr (exp_raddr),
        .rdata (exp_rdata)
    );

    sdtq_ram #(
        .WIDTH(COOKIE_BITS),
        .DEPTH(SLOT_COUNT)
    ) u_cookie_ram (
        .clk   (clk),
        .we    (ck_we),
        .waddr (id_reg),
        .wdata (ck_reg),
        .raddr (fire_reg[emit_reg[SLOT_BITS-1:0]]),
        .rdata (ck_rdata)
    );

    // shared subtractor operands
    always_comb
    begin
        op_a = exp_rdata;
        op_b = now_reg;
        case (state_reg)
            SEQ_FIND_CMP:
            begin
                op_a = exp_reg;
                op_b = exp_rdata;
            end
            SEQ_DISP_CMP:
            begin
                op_a = now_reg;
                op_b = exp_rdata;
            end
            default:
            begin
                op_a = exp_rdata;
                op_b = now_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            SEQ_SHIFT:   ord_raddr = idx_lo - SLOT_BITS'(1);
            SEQ_HEAD_RD: ord_raddr = '0;
            default:     ord_raddr = idx_lo;
        endcase
    end

    assign exp_raddr = (state_reg == SEQ_MOD_RD) ? id_reg : ord_rd;
    assign keep_elem = (state_reg == SEQ_UNLINK) ? (ord_rd != id_reg) : diff[TIME_BITS-1];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        exp_next        = exp_reg;
        ck_next         = ck_reg;
        now_next        = now_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        nfire_next      = nfire_reg;
        emit_next       = emit_reg;
        nd_next         = nd_reg;
        pending_next    = pending_reg;
        ord_we          = 1'b0;
        ord_waddr       = keep_reg[SLOT_BITS-1:0];
        ord_wdata       = ord_rd;
        fire_we         = 1'b0;
        exp_we          = 1'b0;
        ck_we           = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_ck_next     = out_ck_reg;
        out_nd_next     = out_nd_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next    = s_tuser;
                    id_next     = s_tdata[3:0];
                    exp_next    = s_tdata[35:4];
                    ck_next     = s_tdata[67:36];
                    now_next    = s_tdata[99:68];
                    status_next = STAT_DONE;
                    idx_next    = '0;
                    keep_next   = '0;
                    nfire_next  = '0;
                    emit_next   = '0;
                    case (s_tuser)
                        CMD_DISPATCH:
                            state_next = (count_reg == '0) ? SEQ_HEAD_RD : SEQ_DISP_RD;
                        CMD_MODIFY:
                            state_next = SEQ_MOD_RD;
                        CMD_ADD:
                            state_next = pending_reg[s_tdata[3:0]] ? SEQ_UNLINK : SEQ_WRITE;
                        default:
                            state_next = pending_reg[s_tdata[3:0]] ? SEQ_UNLINK : SEQ_HEAD_RD;
                    endcase
                end
            end

            SEQ_MOD_RD:
            begin
                state_next = SEQ_MOD_CHK;
            end

            SEQ_MOD_CHK:
            begin
                if (pending_reg[id_reg] && exp_rdata == exp_reg)
                begin
                    status_next = STAT_UNCHANGED;
                    state_next  = SEQ_HEAD_RD;
                end
                else if (pending_reg[id_reg])
                begin
                    state_next = SEQ_UNLINK;
                end
                else
                begin
                    state_next = SEQ_WRITE;
                end
            end

            // compacting pass that drops the slot from the order list
            SEQ_UNLINK:
            begin
                if (keep_elem)
                begin
                    ord_we    = 1'b1;
                    keep_next = keep_reg + CNT_BITS'(1);
                end
                idx_next = idx_reg + CNT_BITS'(1);
                if (last_elem)
                begin
                    count_next           = keep_reg + CNT_BITS'(keep_elem);
                    pending_next[id_reg] = 1'b0;
                    state_next = (cmd_reg == CMD_DELETE) ? SEQ_HEAD_RD : SEQ_WRITE;
                end
            end

            SEQ_WRITE:
            begin
                exp_we   = 1'b1;
                ck_we    = (cmd_reg == CMD_ADD);
                idx_next = '0;
                if (count_reg == CNT_BITS'(SLOT_COUNT))
                begin
                    state_next = SEQ_HEAD_RD;
                end
                else if (count_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = SEQ_PLACE;
                end
                else
                begin
                    state_next = SEQ_FIND_RD;
                end
            end

            SEQ_FIND_RD:
            begin
                state_next = SEQ_FIND_CMP;
            end

            // first entry that the new expiry comes before
            SEQ_FIND_CMP:
            begin
                if (diff[TIME_BITS-1])
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = SEQ_SHIFT;
                end
                else if (last_elem)
                begin
                    pos_next   = count_reg;
                    state_next = SEQ_PLACE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_BITS'(1);
                    state_next = SEQ_FIND_RD;
                end
            end

            SEQ_SHIFT:
            begin
                ord_we    = 1'b1;
                ord_waddr = idx_lo;
                idx_next  = idx_reg - CNT_BITS'(1);
                if (idx_reg - CNT_BITS'(1) == pos_reg)
                begin
                    state_next = SEQ_PLACE;
                end
            end

            SEQ_PLACE:
            begin
                ord_we               = 1'b1;
                ord_waddr            = pos_reg[SLOT_BITS-1:0];
                ord_wdata            = id_reg;
                count_next           = count_reg + CNT_BITS'(1);
                pending_next[id_reg] = 1'b1;
                state_next           = SEQ_HEAD_RD;
            end

            SEQ_DISP_RD:
            begin
                state_next = SEQ_DISP_CMP;
            end

            // keep entries still ahead of now, collect the rest
            SEQ_DISP_CMP:
            begin
                if (keep_elem)
                begin
                    ord_we    = 1'b1;
                    keep_next = keep_reg + CNT_BITS'(1);
                end
                else
                begin
                    fire_we              = 1'b1;
                    nfire_next           = nfire_reg + CNT_BITS'(1);
                    pending_next[ord_rd] = 1'b0;
                end
                idx_next = idx_reg + CNT_BITS'(1);
                if (last_elem)
                begin
                    count_next = keep_reg + CNT_BITS'(keep_elem);
                    state_next = SEQ_HEAD_RD;
                end
                else
                begin
                    state_next = SEQ_DISP_RD;
                end
            end

            SEQ_HEAD_RD:
            begin
                if (count_reg == '0)
                begin
                    nd_next = idle_reg;
                    if (cmd_reg == CMD_DISPATCH && nfire_reg != '0)
                    begin
                        state_next = SEQ_COOK_RD;
                    end
                    else
                    begin
                        state_next = SEQ_FINAL;
                    end
                end
                else
                begin
                    state_next = SEQ_HEAD_CMP;
                end
            end

            SEQ_HEAD_CMP:
            begin
                nd_next = diff[TIME_BITS-1] ? '0 : DELAY_BITS'(diff);
                if (cmd_reg == CMD_DISPATCH && nfire_reg != '0)
                begin
                    state_next = SEQ_COOK_RD;
                end
                else
                begin
                    state_next = SEQ_FINAL;
                end
            end

            SEQ_COOK_RD:
            begin
                state_next = SEQ_FIRE;
            end

            SEQ_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_FIRED;
                    out_id_next     = fire_reg[emit_reg[SLOT_BITS-1:0]];
                    out_ck_next     = ck_rdata;
                    out_nd_next     = nd_reg;
                    out_last_next   = (emit_reg == nfire_reg - CNT_BITS'(1));
                    emit_next       = emit_reg + CNT_BITS'(1);
                    if (emit_reg == nfire_reg - CNT_BITS'(1))
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        state_next = SEQ_COOK_RD;
                    end
                end
            end

            SEQ_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = (cmd_reg == CMD_DISPATCH) ? STAT_NONE : status_reg;
                    out_id_next     = '0;
                    out_ck_next     = '0;
                    out_nd_next     = nd_reg;
                    out_last_next   = 1'b1;
                    state_next      = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            count_reg     <= '0;
            pending_reg   <= '0;
            idle_reg      <= IDLE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                idle_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        exp_reg        <= exp_next;
        ck_reg         <= ck_next;
        now_reg        <= now_next;
        status_reg     <= status_next;
        idx_reg        <= idx_next;
        keep_reg       <= keep_next;
        pos_reg        <= pos_next;
        nfire_reg      <= nfire_next;
        emit_reg       <= emit_next;
        nd_reg         <= nd_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_ck_reg     <= out_ck_next;
        out_nd_reg     <= out_nd_next;
        out_last_reg   <= out_last_next;
        if (ord_we)
        begin
            order_reg[ord_waddr] <= ord_wdata;
        end
        if (fire_we)
        begin
            fire_reg[nfire_reg[SLOT_BITS-1:0]] <= ord_rd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_nd_reg, out_ck_reg, out_id_reg};

endmodule
